// ----- rtl/tkt_pkg.sv -----
`timescale 1ns / 1ps

package tkt_pkg;

  localparam int unsigned NODE_COUNT_DEF = 256;
  localparam int unsigned TYPE_COUNT     = 64;
  localparam int unsigned SYMBOLS        = 37;
  localparam int unsigned SYM_DIGIT0     = 26;
  localparam int unsigned SYM_UNDERSCORE = 36;

  localparam int unsigned TYPE_W  = 6;
  localparam int unsigned IDENT_W = 9;
  localparam int unsigned NEXT_W  = 8;

  localparam logic [IDENT_W-1:0] NO_INDEX  = 9'h1FF;
  localparam logic [NEXT_W-1:0]  INDEX_MAX = 8'hFF;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_MISS    = 2'd1;
  localparam logic [1:0] STAT_BADCHAR = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  typedef struct packed {
    logic       ok;
    logic [5:0] code;
  } sym_t;

  // a-z -> 0..25, 0-9 -> 26..35, '_' -> 36
  function automatic sym_t sym_of(input logic [7:0] ch);
    sym_t s;
    s.ok   = 1'b1;
    s.code = '0;
    if (ch >= 8'h61 && ch <= 8'h7A) begin
      s.code = 6'(ch - 8'h61);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      s.code = 6'(ch - 8'h30) + 6'(SYM_DIGIT0);
    end else if (ch == 8'h5F) begin
      s.code = 6'(SYM_UNDERSCORE);
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

// ----- rtl/trie_keyword_table.sv -----
`timescale 1ns / 1ps
// Steps: a character beat reads its child link on accept, then walks or
//   allocates in S_LINK; a tlast beat adds the node info read (S_FINRD) and
//   update (S_FIN), result registered; a full output register stalls S_FIN.
// A new beat is taken only in S_IDLE, once the last one is through.
// Reset: all control state cleared, then the child link memory is swept to
//   zero, one entry a cycle, NODE_COUNT*37 entries, with s_axis_tready low.
module trie_keyword_table #(
  parameter int unsigned NODE_COUNT = tkt_pkg::NODE_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,     // error_token_code
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,    // [7:0] char_code, [8] is_identifier,
                                       // [14:9] token_type, [15] zero
  input  logic        s_axis_tuser,    // operation
  input  logic        s_axis_tlast,    // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,    // [5:0] found_type, [14:6] ident_index,
                                       // [15] zero
  output logic [1:0]  m_axis_tuser     // status
);
  import tkt_pkg::*;

  localparam int unsigned NW    = $clog2(NODE_COUNT);
  localparam int unsigned DEPTH = NODE_COUNT * SYMBOLS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned INFO_W = TYPE_W + IDENT_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LINK  = 3'd2;
  localparam logic [2:0] S_FINRD = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [5:0]        err_code_q;
  logic [NW-1:0]     cur_q, cur_d;
  logic              abort_q, abort_d;
  logic [1:0]        werr_q, werr_d;
  logic [NW:0]       nf_q, nf_d;
  logic [NEXT_W-1:0] nid_q, nid_d;

  logic              op_q, last_q, isid_q, walk_q, walk_d;
  logic [TYPE_W-1:0] tt_q;
  logic [AW-1:0]     addr_q;

  logic              out_valid_q, out_valid_d;
  logic [TYPE_W-1:0] out_type_q, out_type_d;
  logic [IDENT_W-1:0] out_idx_q, out_idx_d;
  logic [1:0]        out_stat_q, out_stat_d;

  // child link memory
  logic [NW-1:0]     ch_mem [DEPTH];
  logic              ch_we, ch_re;
  logic [AW-1:0]     ch_waddr, ch_raddr;
  logic [NW-1:0]     ch_wdata, ch_rdata_q;

  // node info memory: {type, ident}
  logic [INFO_W-1:0] nd_mem [NODE_COUNT];
  logic              nd_we, nd_re;
  logic [NW-1:0]     nd_addr;
  logic [INFO_W-1:0] nd_wdata, nd_rdata_q;

  logic              accept;
  sym_t              sym;
  logic [AW-1:0]     link_addr;
  logic [TYPE_W-1:0] new_type;
  logic [IDENT_W-1:0] new_idx;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign sym       = sym_of(s_axis_tdata[7:0]);
  assign link_addr = AW'(cur_q) * AW'(SYMBOLS) + AW'(sym.code);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_idx_q, out_type_q};
  assign m_axis_tuser  = out_stat_q;

  always_ff @(posedge clk_i) begin
    if (ch_we) begin
      ch_mem[ch_waddr] <= ch_wdata;
    end
    if (ch_re) begin
      ch_rdata_q <= ch_mem[ch_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (nd_we) begin
      nd_mem[nd_addr] <= nd_wdata;
    end
    if (nd_re) begin
      nd_rdata_q <= nd_mem[nd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_code_q <= '0;
    end else if (cfg_we_i) begin
      err_code_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cur_d       = cur_q;
    abort_d     = abort_q;
    werr_d      = werr_q;
    nf_d        = nf_q;
    nid_d       = nid_q;
    walk_d      = walk_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_type_d  = out_type_q;
    out_idx_d   = out_idx_q;
    out_stat_d  = out_stat_q;
    ch_we       = 1'b0;
    ch_re       = 1'b0;
    ch_waddr    = addr_q;
    ch_raddr    = link_addr;
    ch_wdata    = cur_d;
    nd_we       = 1'b0;
    nd_re       = 1'b0;
    nd_addr     = cur_q;
    nd_wdata    = {err_code_q, NO_INDEX};
    new_type    = (32'(tt_q) < TYPE_COUNT) ? tt_q : err_code_q;
    new_idx     = isid_q ? {1'b0, nid_q} : nd_rdata_q[IDENT_W-1:0];

    unique case (state_q)
      S_CLEAR: begin
        ch_we    = 1'b1;
        ch_waddr = clr_q;
        ch_wdata = '0;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          walk_d  = !abort_q && sym.ok;
          ch_re   = !abort_q && sym.ok;
          if (!abort_q && !sym.ok) begin
            abort_d = 1'b1;
            werr_d  = STAT_BADCHAR;
          end
          state_d = S_LINK;
        end
      end
      S_LINK: begin
        if (walk_q) begin
          if (ch_rdata_q != '0) begin
            cur_d = ch_rdata_q;
          end else if (op_q) begin
            if (nf_q >= (NW+1)'(NODE_COUNT)) begin
              abort_d = 1'b1;
              werr_d  = STAT_FULL;
            end else begin
              // allocate: link it in and give it the fresh-node info
              cur_d    = nf_q[NW-1:0];
              nf_d     = nf_q + (NW+1)'(1);
              ch_we    = 1'b1;
              ch_wdata = nf_q[NW-1:0];
              nd_we    = 1'b1;
              nd_addr  = nf_q[NW-1:0];
            end
          end else begin
            abort_d = 1'b1;
            werr_d  = STAT_MISS;
          end
        end
        state_d = last_q ? S_FINRD : S_IDLE;
      end
      S_FINRD: begin
        nd_re   = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          if (abort_q) begin
            out_type_d = err_code_q;
            out_idx_d  = NO_INDEX;
            out_stat_d = werr_q;
          end else begin
            out_stat_d = STAT_OK;
            if (op_q) begin
              nd_we      = 1'b1;
              nd_wdata   = {new_type, new_idx};
              out_type_d = new_type;
              out_idx_d  = new_idx;
              if (isid_q && nid_q != INDEX_MAX) begin
                nid_d = nid_q + NEXT_W'(1);
              end
            end else begin
              out_type_d = nd_rdata_q[INFO_W-1:IDENT_W];
              out_idx_d  = nd_rdata_q[IDENT_W-1:0];
            end
          end
          cur_d   = '0;
          abort_d = 1'b0;
          werr_d  = STAT_OK;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cur_q       <= '0;
      abort_q     <= 1'b0;
      werr_q      <= STAT_OK;
      nf_q        <= (NW+1)'(1);
      nid_q       <= '0;
      walk_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cur_q       <= cur_d;
      abort_q     <= abort_d;
      werr_q      <= werr_d;
      nf_q        <= nf_d;
      nid_q       <= nid_d;
      walk_q      <= walk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= s_axis_tuser;
      last_q <= s_axis_tlast;
      isid_q <= s_axis_tdata[8];
      tt_q   <= s_axis_tdata[14:9];
      addr_q <= link_addr;
    end
    out_type_q <= out_type_d;
    out_idx_q  <= out_idx_d;
    out_stat_q <= out_stat_d;
  end

endmodule

// ----- tb/sv/trie_keyword_table_tb.sv -----
`timescale 1ns / 1ps

module trie_keyword_table_tb;
  import tkt_pkg::*;

  localparam int unsigned NODES = NODE_COUNT_DEF;
  localparam int MAX_WORD    = 16;
  localparam int VOCAB_MAX   = 512;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 600;
  localparam int PHASE_BEATS = 630;

  localparam bit OP_SEARCH = 1'b0;
  localparam bit OP_INSERT = 1'b1;

  localparam logic [7:0] CH_A  = 8'h61;
  localparam logic [7:0] CH_Z  = 8'h7A;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_US = 8'h5F;

  typedef struct packed {
    logic [TYPE_W-1:0]  ftype;
    logic [IDENT_W-1:0] ident;
    logic [1:0]         status;
  } lookup_t;

  class trie_scoreboard;
    logic [7:0]         child  [NODES*SYMBOLS];
    logic [TYPE_W-1:0]  ntype  [NODES];
    logic [IDENT_W-1:0] nident [NODES];
    int unsigned        cur_node;
    int unsigned        next_free;
    int unsigned        next_ident;
    bit                 aborted;
    logic [1:0]         word_err;
    logic [TYPE_W-1:0]  err_code;
    lookup_t            pending_q[$];
    lookup_t            last_pred;
    int                 fail_count;

    function new();
      foreach (child[i]) child[i] = '0;
      foreach (ntype[i]) ntype[i] = '0;
      foreach (nident[i]) nident[i] = '0;
      cur_node   = 0;
      next_free  = 1;
      next_ident = 0;
      aborted    = 1'b0;
      word_err   = STAT_OK;
      err_code   = '0;
      fail_count = 0;
    endfunction

    // -1 for anything outside a-z, 0-9 and underscore
    function int symbol(logic [7:0] ch);
      if (ch >= CH_A && ch <= CH_Z) return int'(ch - CH_A);
      if (ch >= CH_0 && ch <= CH_9) return int'(SYM_DIGIT0) + int'(ch - CH_0);
      if (ch == CH_US) return int'(SYM_UNDERSCORE);
      return -1;
    endfunction

    function void note_beat(bit op, logic [7:0] ch, bit last, bit isid,
                            logic [TYPE_W-1:0] tt);
      int          sym;
      int unsigned slot;
      int unsigned n;
      lookup_t     res;
      if (!aborted) begin
        sym = symbol(ch);
        if (sym < 0) begin
          aborted  = 1'b1;
          word_err = STAT_BADCHAR;
        end else begin
          slot = cur_node * SYMBOLS + sym;
          if (child[slot] != '0) begin
            cur_node = child[slot];
          end else if (op == OP_INSERT) begin
            if (next_free >= NODES) begin
              aborted  = 1'b1;
              word_err = STAT_FULL;
            end else begin
              n = next_free;
              next_free++;
              child[slot]  = n[7:0];
              ntype[n]     = err_code;
              nident[n]    = NO_INDEX;
              cur_node     = n;
            end
          end else begin
            aborted  = 1'b1;
            word_err = STAT_MISS;
          end
        end
      end
      if (!last) return;
      if (aborted) begin
        res = '{ftype: err_code, ident: NO_INDEX, status: word_err};
      end else begin
        if (op == OP_INSERT) begin
          ntype[cur_node] = (tt < TYPE_COUNT) ? tt : err_code;
          if (isid) begin
            nident[cur_node] = next_ident[IDENT_W-1:0];
            if (next_ident < INDEX_MAX) next_ident++;
          end
        end
        res = '{ftype: ntype[cur_node], ident: nident[cur_node], status: STAT_OK};
      end
      pending_q.push_back(res);
      last_pred = res;
      cur_node  = 0;
      aborted   = 1'b0;
      word_err  = STAT_OK;
    endfunction

    function void report(string what, lookup_t want, lookup_t got);
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: %s: expected type %0d index %h status %0d, got type %0d index %h status %0d",
                 $realtime, what, want.ftype, want.ident, want.status,
                 got.ftype, got.ident, got.status);
    endfunction

    function void check_result(lookup_t got);
      lookup_t want;
      if (pending_q.size() == 0) begin
        report("result with nothing pending", '0, got);
        return;
      end
      want = pending_q.pop_front();
      if (got.ftype !== want.ftype || got.ident !== want.ident ||
          got.status !== want.status)
        report("lookup mismatch", want, got);
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [5:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  trie_keyword_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  trie_scoreboard sb = new();

  logic [7:0] wbuf [MAX_WORD];
  bit         wops [MAX_WORD];
  int         wlen;
  logic [7:0] vocab [VOCAB_MAX][MAX_WORD];
  int         vocab_len [VOCAB_MAX];
  int         vocab_n    = 0;
  int         beats_sent = 0;
  bit         send_burst = 1'b0;

  function automatic int draw_gap();
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic logic [7:0] valid_char();
    int sym;
    sym = $urandom_range(0, SYMBOLS - 1);
    if (sym < SYM_DIGIT0) return CH_A + 8'(sym);
    if (sym < SYM_UNDERSCORE) return CH_0 + 8'(sym - SYM_DIGIT0);
    return CH_US;
  endfunction

  function automatic logic [7:0] bad_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (sb.symbol(c) >= 0);
    return c;
  endfunction

  // mostly short words so identifiers run out and the pool fills
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 2);
    if (r < 9) return $urandom_range(3, 5);
    return $urandom_range(6, 12);
  endfunction

  function automatic void make_random(int len);
    wlen = len;
    for (int i = 0; i < len; i++) wbuf[i] = valid_char();
  endfunction

  function automatic void load_vocab(int k, int plen);
    wlen = (plen > 0) ? plen : vocab_len[k];
    for (int i = 0; i < wlen; i++) wbuf[i] = vocab[k][i];
  endfunction

  function automatic void load_text(string txt);
    wlen = txt.len();
    for (int i = 0; i < wlen; i++) wbuf[i] = txt[i];
  endfunction

  function automatic void set_ops(bit op);
    for (int i = 0; i < MAX_WORD; i++) wops[i] = op;
  endfunction

  task automatic send_beat(input bit op, input logic [7:0] ch, input bit last,
                           input bit isid, input logic [5:0] tt);
    int gap;
    gap = send_burst ? 0 : draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, tt, isid, ch};
    s_axis_tuser  <= op;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_beat(op, ch, last, isid, tt);
    beats_sent++;
  endtask

  // isid and token type only count on the last beat; others get noise
  task automatic send_word(input bit isid, input logic [5:0] tt);
    bit last;
    for (int i = 0; i < wlen; i++) begin
      last = (i == wlen - 1);
      send_beat(wops[i], wbuf[i], last, last ? isid : 1'($urandom),
                last ? tt : 6'($urandom));
    end
  endtask

  task automatic directed(input string txt, input bit op, input bit isid,
                          input logic [5:0] tt);
    load_text(txt);
    set_ops(op);
    send_word(isid, tt);
  endtask

  task automatic random_word();
    int kind;
    int k;
    int len;
    bit fresh;
    bit isid;
    bit op;
    logic [5:0] tt;
    kind  = $urandom_range(0, 99);
    len   = pick_len();
    fresh = 1'b0;
    isid  = 1'($urandom);
    tt    = 6'($urandom);
    if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
    if (kind < 55) begin
      if (vocab_n > 0 && $urandom_range(0, 99) < 70) begin
        load_vocab($urandom_range(0, vocab_n - 1), 0);
      end else begin
        make_random(len);
        fresh = 1'b1;
      end
      isid = ($urandom_range(0, 9) != 0);
      set_ops(OP_INSERT);
      send_word(isid, tt);
      if (fresh && sb.last_pred.status == STAT_OK && vocab_n < VOCAB_MAX) begin
        for (int i = 0; i < wlen; i++) vocab[vocab_n][i] = wbuf[i];
        vocab_len[vocab_n] = wlen;
        vocab_n++;
      end
    end else if (kind < 85) begin
      k = $urandom_range(0, 9);
      if (vocab_n > 0 && k < 6) begin
        load_vocab($urandom_range(0, vocab_n - 1), 0);
      end else if (vocab_n > 0 && k < 8) begin
        k = $urandom_range(0, vocab_n - 1);
        load_vocab(k, $urandom_range(1, vocab_len[k]));
      end else begin
        make_random(len);
      end
      set_ops(OP_SEARCH);
      send_word(isid, tt);
    end else if (kind < 92) begin
      // broken word: one bad byte somewhere, rest ignored up to last
      make_random(len + 1);
      wbuf[$urandom_range(0, wlen - 1)] = bad_char();
      op = 1'($urandom);
      set_ops(op);
      send_word(isid, tt);
    end else begin
      if (vocab_n > 0 && $urandom_range(0, 1) == 0)
        load_vocab($urandom_range(0, vocab_n - 1), 0);
      else
        make_random(len);
      for (int i = 0; i < wlen; i++) wops[i] = 1'($urandom);
      send_word(isid, tt);
    end
  endtask

  task automatic run_phase(input int beats);
    int stop_at;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) random_word();
    s_axis_tvalid <= 1'b0;
  endtask

  // block must be idle: results drained, then room for a trailing char beat
  task automatic write_error_code(input logic [5:0] code);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= code;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.err_code = code;
  endtask

  initial begin : result_sink
    lookup_t got;
    int      gap;
    int      taken;
    bit      sink_burst;
    taken      = 0;
    sink_burst = 1'b0;
    forever begin
      if ($urandom_range(0, 11) == 0) sink_burst = !sink_burst;
      if (taken == HOLD_AT) gap = HOLD_CYCLES;
      else gap = sink_burst ? 0 : draw_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.ftype  = m_axis_tdata[5:0];
      got.ident  = m_axis_tdata[14:6];
      got.status = m_axis_tuser;
      sb.check_result(got);
      taken++;
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_error_code(6'h3F);
    directed("a", OP_SEARCH, 1'b0, 6'h00);   // empty table
    directed("a", OP_INSERT, 1'b1, 6'h00);
    directed("ab", OP_INSERT, 1'b0, 6'h3F);
    directed("ab", OP_SEARCH, 1'b0, 6'h00);
    directed("a", OP_SEARCH, 1'b1, 6'h3F);
    directed("z9_", OP_INSERT, 1'b1, 6'h05);
    directed("z9", OP_SEARCH, 1'b0, 6'h00);  // prefix only
    directed("0_", OP_INSERT, 1'b1, 6'h2A);
    load_text("qxx");
    wbuf[1] = 8'hFF;
    set_ops(OP_INSERT);
    send_word(1'b1, 6'h01);
    directed("q", OP_SEARCH, 1'b0, 6'h00);   // left behind by the abort
    load_text("x");
    wbuf[0] = 8'h00;
    set_ops(OP_INSERT);
    send_word(1'b1, 6'h02);
    // op taken per beat: search walks, insert allocates on the last
    load_text("ac");
    wops[0] = OP_SEARCH;
    wops[1] = OP_INSERT;
    send_word(1'b1, 6'h02);
    load_text("de");
    wops[0] = OP_INSERT;
    wops[1] = OP_SEARCH;
    send_word(1'b0, 6'h00);
    directed("a", OP_INSERT, 1'b0, 6'h07);   // keeps its index
    s_axis_tvalid <= 1'b0;

    write_error_code(6'h00);
    run_phase(PHASE_BEATS);
    write_error_code(6'($urandom_range(1, 62)));
    run_phase(PHASE_BEATS);
    write_error_code(6'h15);
    run_phase(PHASE_BEATS);

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.fail_count == 0) begin
      $display("trie_keyword_table verification clean");
    end else begin
      $display("trie_keyword_table verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("trie_keyword_table verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/tkt_pkg.sv
rtl/trie_keyword_table.sv
tb/sv/trie_keyword_table_tb.sv
